// File: rtl/svpwm_pkg.sv
package svpwm_pkg;

   localparam int FRAC_BITS_DEF = 14;

   // field and datapath widths
   localparam int REF_W  = 16;
   localparam int ANG_W  = 16;
   localparam int CMP_W  = 16;
   localparam int CFG_W  = 13;
   localparam int QUOT_W = 15;
   localparam int DUTY_W = 20;
   localparam int NUM_W  = 17;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   localparam logic [CMP_W-1:0] PERIOD_RESET = 16'd1000;

   // sector bounds in angle ticks, 65536 per turn
   localparam logic [ANG_W-1:0] A_LO = 16'd16384;
   localparam logic [ANG_W-1:0] A_HI = 16'd49152;
   localparam logic [ANG_W-1:0] B_LO = 16'd5461;
   localparam logic [ANG_W-1:0] B_HI = 16'd38229;
   localparam logic [ANG_W-1:0] C_LO = 16'd27306;
   localparam logic [ANG_W-1:0] C_HI = 16'd60074;

   typedef enum logic [1:0] {
      REG_PERIOD    = 2'd0,
      REG_DEAD_COMP = 2'd1,
      REG_MIN_DUTY  = 2'd2
   } reg_index_type;

   // per-request data that rides alongside the divider
   typedef struct packed {
      logic [2:0][REF_W-1:0] refs;
      logic [REF_W-1:0]      span;
      logic                  over;
      logic [2:0]            add;
   } side_type;

   function automatic logic [REF_W-1:0] ref_mag(input logic [REF_W-1:0] r);
      return r[REF_W-1] ? REF_W'(-r) : r;
   endfunction

endpackage

// File: rtl/svpwm_duty_with_dead_time_comp_top.sv
// SVPWM duty generator with min-max zero-sequence injection and dead-time
// compensation by angle sector.
// Request channel (req_valid/req_ready): three signed Q2.14 phase references
// and an electrical angle. Response channel (rsp_valid/rsp_ready): three timer
// compare values and the overmodulation flag, one response per request, in
// request order.
// Registers on the APB port: period_counts at 0x0, dead_comp at 0x4,
// min_duty at 0x8. Write them only while no request is in flight.
// From request acceptance to rsp_valid the path is an input stage, 15
// divider stages (one quotient bit each, for the span scaling), then scale
// select, duty sum, clamp, multiply and output stages.
// Throughput: one request per cycle while rsp_ready is held high.
// Reset clears every valid bit and loads the register reset values; no
// request is in flight afterwards.
// When the receiver holds rsp_ready low, the response holds and the pipeline
// keeps taking requests until every stage is full; then req_ready drops.
module svpwm_duty_with_dead_time_comp_top #(
   parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [svpwm_pkg::REF_W-1:0]  req_ref_a,
   input  logic signed [svpwm_pkg::REF_W-1:0]  req_ref_b,
   input  logic signed [svpwm_pkg::REF_W-1:0]  req_ref_c,
   input  logic [svpwm_pkg::ANG_W-1:0]         req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [svpwm_pkg::CMP_W-1:0]         rsp_compare_a,
   output logic [svpwm_pkg::CMP_W-1:0]         rsp_compare_b,
   output logic [svpwm_pkg::CMP_W-1:0]         rsp_compare_c,
   output logic                                rsp_over_modulated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [svpwm_pkg::ADDR_W-1:0]        paddr,
   input  logic [svpwm_pkg::DATA_W-1:0]        pwdata,
   output logic [svpwm_pkg::DATA_W-1:0]        prdata,
   output logic                                pready
);

   localparam int ONE = 1 << FRAC_BITS;
   localparam int RW  = svpwm_pkg::REF_W;
   localparam int QW  = svpwm_pkg::QUOT_W;
   localparam int DW  = svpwm_pkg::DUTY_W;
   localparam int NW  = svpwm_pkg::NUM_W;
   localparam int CW  = svpwm_pkg::CMP_W;
   localparam int PW  = NW + CW;

   // ---------------- registers ----------------
   logic [CW-1:0]               period_ff;
   logic [svpwm_pkg::CFG_W-1:0] dead_comp_ff;
   logic [svpwm_pkg::CFG_W-1:0] min_duty_ff;
   logic                        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= svpwm_pkg::PERIOD_RESET;
         dead_comp_ff <= '0;
         min_duty_ff  <= '0;
      end else if (csr_write) begin
         case (svpwm_pkg::reg_index_type'(paddr[3:2]))
            svpwm_pkg::REG_PERIOD:    period_ff    <= pwdata[CW-1:0];
            svpwm_pkg::REG_DEAD_COMP: dead_comp_ff <= pwdata[svpwm_pkg::CFG_W-1:0];
            svpwm_pkg::REG_MIN_DUTY:  min_duty_ff  <= pwdata[svpwm_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (svpwm_pkg::reg_index_type'(paddr[3:2]))
         svpwm_pkg::REG_PERIOD:    prdata = svpwm_pkg::DATA_W'(period_ff);
         svpwm_pkg::REG_DEAD_COMP: prdata = svpwm_pkg::DATA_W'(dead_comp_ff);
         svpwm_pkg::REG_MIN_DUTY:  prdata = svpwm_pkg::DATA_W'(min_duty_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------- handshake chain ----------------
   logic s0_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, rsp_valid_ff;
   logic s0_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy;
   logic div_in_ready, div_out_valid;

   assign f_rdy     = !rsp_valid_ff || rsp_ready;
   assign e_rdy     = !e_valid_ff || f_rdy;
   assign d_rdy     = !d_valid_ff || e_rdy;
   assign c_rdy     = !c_valid_ff || d_rdy;
   assign b_rdy     = !b_valid_ff || c_rdy;
   assign s0_rdy    = !s0_valid_ff || div_in_ready;
   assign req_ready = s0_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_rdy) s0_valid_ff  <= req_valid;
         if (b_rdy)  b_valid_ff   <= div_out_valid;
         if (c_rdy)  c_valid_ff   <= b_valid_ff;
         if (d_rdy)  d_valid_ff   <= c_valid_ff;
         if (e_rdy)  e_valid_ff   <= d_valid_ff;
         if (f_rdy)  rsp_valid_ff <= e_valid_ff;
      end
   end

   // ---------------- input stage: bounds, span, sectors ----------------
   svpwm_pkg::side_type s0_side_in, s0_side_ff;
   logic signed [RW-1:0] in_mx, in_mn;
   logic signed [RW:0]   in_span;

   always_comb begin
      in_mx = req_ref_a;
      in_mn = req_ref_a;
      if (req_ref_b > in_mx) in_mx = req_ref_b;
      if (req_ref_c > in_mx) in_mx = req_ref_c;
      if (req_ref_b < in_mn) in_mn = req_ref_b;
      if (req_ref_c < in_mn) in_mn = req_ref_c;
      in_span = (RW+1)'(in_mx) - (RW+1)'(in_mn);

      s0_side_in.refs = {req_ref_c, req_ref_b, req_ref_a};
      s0_side_in.span = in_span[RW-1:0];
      s0_side_in.over = {1'b0, in_span[RW-1:0]} > (RW+1)'(ONE);
      s0_side_in.add[0] = !(req_angle > svpwm_pkg::A_LO && req_angle <= svpwm_pkg::A_HI);
      s0_side_in.add[1] = req_angle > svpwm_pkg::B_LO && req_angle <= svpwm_pkg::B_HI;
      s0_side_in.add[2] = req_angle > svpwm_pkg::C_LO && req_angle <= svpwm_pkg::C_HI;
   end

   always_ff @(posedge clock) begin
      if (s0_rdy && req_valid) s0_side_ff <= s0_side_in;
   end

   // ---------------- span scaling ----------------
   logic [2:0][QW-1:0]  div_quot;
   svpwm_pkg::side_type div_side;

   svpwm_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_ready  (div_in_ready),
      .in_side   (s0_side_ff),
      .out_valid (div_out_valid),
      .out_ready (b_rdy),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // ---------------- stage B: select scaled refs, max, min ----------------
   logic [2:0][RW-1:0] b_s_in, b_s_ff;
   logic [RW-1:0]      b_mx_in, b_mn_in, b_mx_ff, b_mn_ff;
   logic [2:0]         b_add_ff;
   logic               b_over_ff;

   always_comb begin
      logic [RW-1:0] q16;
      for (int l = 0; l < 3; l++) begin
         q16 = RW'(div_quot[l]);
         if (div_side.over) begin
            b_s_in[l] = div_side.refs[l][RW-1] ? RW'(-q16) : q16;
         end else begin
            b_s_in[l] = div_side.refs[l];
         end
      end
      b_mx_in = b_s_in[0];
      b_mn_in = b_s_in[0];
      for (int l = 1; l < 3; l++) begin
         if ($signed(b_s_in[l]) > $signed(b_mx_in)) b_mx_in = b_s_in[l];
         if ($signed(b_s_in[l]) < $signed(b_mn_in)) b_mn_in = b_s_in[l];
      end
   end

   always_ff @(posedge clock) begin
      if (b_rdy && div_out_valid) begin
         b_s_ff    <= b_s_in;
         b_mx_ff   <= b_mx_in;
         b_mn_ff   <= b_mn_in;
         b_add_ff  <= div_side.add;
         b_over_ff <= div_side.over;
      end
   end

   // ---------------- stage C: doubled duty with offset and compensation ----------------
   logic [2:0][DW-1:0] c_d2_in, c_d2_ff;
   logic               c_over_ff;

   always_comb begin
      logic [DW-1:0] base, dc;
      base = DW'(ONE) - DW'($signed(b_mx_ff)) - DW'($signed(b_mn_ff));
      dc   = DW'({dead_comp_ff, 1'b0});
      for (int l = 0; l < 3; l++) begin
         c_d2_in[l] = (DW'($signed(b_s_ff[l])) << 1) + base + (b_add_ff[l] ? dc : DW'(-dc));
      end
   end

   always_ff @(posedge clock) begin
      if (c_rdy && b_valid_ff) begin
         c_d2_ff   <= c_d2_in;
         c_over_ff <= b_over_ff;
      end
   end

   // ---------------- stage D: clamp, complement ----------------
   logic [2:0][NW-1:0] d_num_in, d_num_ff;
   logic               d_over_ff;

   always_comb begin
      logic [DW-1:0] lo2, hi2, dv, num;
      lo2 = DW'({min_duty_ff, 1'b0});
      hi2 = DW'(2 * ONE) - lo2;
      for (int l = 0; l < 3; l++) begin
         dv = c_d2_ff[l];
         if ($signed(dv) < $signed(lo2)) dv = lo2;
         if ($signed(dv) > $signed(hi2)) dv = hi2;
         num         = DW'(2 * ONE) - dv;
         d_num_in[l] = num[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (d_rdy && c_valid_ff) begin
         d_num_ff  <= d_num_in;
         d_over_ff <= c_over_ff;
      end
   end

   // ---------------- stage E: scale by period ----------------
   logic [2:0][PW-1:0] e_prod_in, e_prod_ff;
   logic               e_over_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         e_prod_in[l] = PW'(d_num_ff[l]) * PW'(period_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (e_rdy && d_valid_ff) begin
         e_prod_ff <= e_prod_in;
         e_over_ff <= d_over_ff;
      end
   end

   // ---------------- stage F: divide by two ones, saturate ----------------
   logic [2:0][CW-1:0] f_cmp_in, f_cmp_ff;
   logic               f_over_ff;

   always_comb begin
      logic [PW-1:0] hi_part;
      for (int l = 0; l < 3; l++) begin
         hi_part     = e_prod_ff[l] >> (FRAC_BITS + 1 + CW);
         f_cmp_in[l] = (|hi_part) ? {CW{1'b1}} : CW'(e_prod_ff[l] >> (FRAC_BITS + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (f_rdy && e_valid_ff) begin
         f_cmp_ff  <= f_cmp_in;
         f_over_ff <= e_over_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_compare_a      = f_cmp_ff[0];
   assign rsp_compare_b      = f_cmp_ff[1];
   assign rsp_compare_c      = f_cmp_ff[2];
   assign rsp_over_modulated = f_over_ff;

   // ---------------- assertions ----------------
   logic quot_ok;

   always_comb begin
      logic [47:0] dividend, low;
      quot_ok = 1'b1;
      for (int l = 0; l < 3; l++) begin
         dividend = 48'(svpwm_pkg::ref_mag(div_side.refs[l])) << FRAC_BITS;
         low      = 48'(div_quot[l]) * 48'(div_side.span);
         if (!(low <= dividend && low + 48'(div_side.span) > dividend)) quot_ok = 1'b0;
      end
   end

   a_quotient_exact: assert property (@(posedge clock) disable iff (reset)
      div_out_valid && div_side.over |-> quot_ok)
      else $error("scaled reference quotient out of bounds");

   a_scaled_span: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_over_ff |->
         ((RW+1)'($signed(b_mx_ff)) - (RW+1)'($signed(b_mn_ff))) <= (RW+1)'(ONE))
      else $error("scaled span exceeds one");

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s0_valid_ff && div_out_valid && b_valid_ff && c_valid_ff &&
                     d_valid_ff && e_valid_ff && rsp_valid_ff)
      else $error("request blocked with an empty stage");

endmodule

// File: rtl/svpwm_div.sv
module svpwm_div #(
   parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  svpwm_pkg::side_type                  in_side,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [2:0][svpwm_pkg::QUOT_W-1:0]    out_quot,
   output svpwm_pkg::side_type                  out_side
);

   localparam int QW = svpwm_pkg::QUOT_W;
   localparam int RW = svpwm_pkg::REF_W + QW;

   logic [QW-1:0]             valid_ff;
   logic [2:0][RW-1:0]        rem_ff    [QW];
   logic [2:0][QW-1:0]        quot_ff   [QW];
   svpwm_pkg::side_type       side_ff   [QW];

   logic [QW-1:0]             v_prev;
   logic [2:0][RW-1:0]        rem_prev  [QW];
   logic [2:0][QW-1:0]        quot_prev [QW];
   svpwm_pkg::side_type       side_prev [QW];

   logic [2:0][RW-1:0]        rem_in    [QW];
   logic [2:0][QW-1:0]        quot_in   [QW];
   logic [QW-1:0]             stage_rdy;

   // stage inputs: the first stage loads |ref| scaled by one
   always_comb begin
      v_prev[0]    = in_valid;
      side_prev[0] = in_side;
      quot_prev[0] = '0;
      for (int l = 0; l < 3; l++) begin
         rem_prev[0][l] = RW'(svpwm_pkg::ref_mag(in_side.refs[l])) << FRAC_BITS;
      end
      for (int j = 1; j < QW; j++) begin
         v_prev[j]    = valid_ff[j-1];
         side_prev[j] = side_ff[j-1];
         rem_prev[j]  = rem_ff[j-1];
         quot_prev[j] = quot_ff[j-1];
      end
   end

   // one restoring step per stage, most significant quotient bit first
   always_comb begin
      logic [RW-1:0] dsh;
      logic [QW-1:0] low_mask;
      for (int j = 0; j < QW; j++) begin
         dsh = RW'(side_prev[j].span) << (QW - 1 - j);
         for (int l = 0; l < 3; l++) begin
            if (rem_prev[j][l] >= dsh) begin
               rem_in[j][l]  = rem_prev[j][l] - dsh;
               quot_in[j][l] = quot_prev[j][l] | (QW'(1) << (QW - 1 - j));
            end else begin
               rem_in[j][l]  = rem_prev[j][l];
               quot_in[j][l] = quot_prev[j][l];
            end
         end
         // a stage may load when some stage at or after it is empty
         low_mask     = (QW'(1) << j) - QW'(1);
         stage_rdy[j] = out_ready || !(&(valid_ff | low_mask));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int j = 0; j < QW; j++) begin
            if (stage_rdy[j]) begin
               valid_ff[j] <= v_prev[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         if (stage_rdy[j] && v_prev[j]) begin
            rem_ff[j]  <= rem_in[j];
            quot_ff[j] <= quot_in[j];
            side_ff[j] <= side_prev[j];
         end
      end
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule
